[hdl/qapm_pkg.sv]
// Shared types, constants and command codes for the attitude PID mixer.
package qapm_pkg;

    localparam int AXIS_COUNT = 3;
    localparam int AXIS_W     = 2;
    localparam logic [AXIS_W-1:0] AXIS_ROLL  = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_PITCH = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_YAW   = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam logic [CFG_IDX_W-1:0] REG_RP_P      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RP_I      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RP_D      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_P     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_I     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_D     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_CTR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CTR = 3'd7;

    localparam logic [31:0] RST_RP_P      = 32'd4194304;
    localparam logic [31:0] RST_RP_I      = 32'd839;
    localparam logic [31:0] RST_RP_D      = 32'd524288000;
    localparam logic [31:0] RST_YAW_P     = 32'd3145728;
    localparam logic [31:0] RST_YAW_I     = 32'd105;
    localparam logic [31:0] RST_YAW_D     = 32'd314572800;
    localparam logic [35:0] RST_STICK_CTR = 36'd25171969500;
    localparam logic [47:0] RST_ANGLE_CTR = 48'd0;

    // floor(2^25 / 125): stick quotient estimate, low by at most one
    localparam logic [18:0] STK_RECIP = 19'd268435;
    localparam int          STK_SHIFT = 25;
    localparam logic [6:0]  STK_DIV   = 7'd125;
    localparam logic [5:0]  STK_ROUND = 6'd62;

    localparam int OUT_SHIFT   = 26;
    localparam int DIV_W       = 52;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = DIV_W / DIV_BITS;

    localparam logic [11:0] CUTOFF_WIDTH = 12'd1350;
    localparam logic [10:0] MIX_OFFSET   = 11'd350;
    localparam logic [10:0] MOTOR_LOW    = 11'd1000;
    localparam logic [10:0] MOTOR_HIGH   = 11'd1600;
    localparam logic [10:0] MOTOR_CUT    = 11'd900;

    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_STK   = 4'd2;
    localparam logic [OP_W-1:0] OP_ERR   = 4'd3;
    localparam logic [OP_W-1:0] OP_ACC   = 4'd4;
    localparam logic [OP_W-1:0] OP_PTERM = 4'd5;
    localparam logic [OP_W-1:0] OP_ILO   = 4'd6;
    localparam logic [OP_W-1:0] OP_IHI   = 4'd7;
    localparam logic [OP_W-1:0] OP_ICLIP = 4'd8;
    localparam logic [OP_W-1:0] OP_DMUL  = 4'd9;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd10;
    localparam logic [OP_W-1:0] OP_FIN   = 4'd11;
    localparam logic [OP_W-1:0] OP_MIX   = 4'd12;

    typedef struct packed {
        logic signed [15:0] angle_roll;
        logic signed [15:0] angle_pitch;
        logic signed [15:0] angle_yaw;
        logic [11:0]        throttle_width;
        logic [11:0]        yaw_stick_width;
        logic [11:0]        roll_stick_width;
        logic [11:0]        pitch_stick_width;
        logic [15:0]        elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic [10:0]        motor_one;
        logic [10:0]        motor_two;
        logic [10:0]        motor_three;
        logic [10:0]        motor_four;
        logic               motors_cut;
        logic signed [15:0] pitch_correction;
        logic signed [15:0] roll_correction;
        logic signed [15:0] yaw_correction;
    } t_out_item;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [AXIS_W-1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

[hdl/qapm_ifs.sv]
// Valid/ready channel interfaces for input and result transactions.
interface qapm_in_if import qapm_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qapm_out_if import qapm_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/qapm_ctrl.sv]
// Sequencer: steps three axes through the shared PID datapath, then mixes.
module qapm_ctrl import qapm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_STK   = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_ACC   = 4'd3;
    localparam logic [3:0] S_PTERM = 4'd4;
    localparam logic [3:0] S_ILO   = 4'd5;
    localparam logic [3:0] S_IHI   = 4'd6;
    localparam logic [3:0] S_ICLIP = 4'd7;
    localparam logic [3:0] S_DMUL  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_FIN   = 4'd10;
    localparam logic [3:0] S_MIX   = 4'd11;

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic [3:0]        r_state, n_state;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= AXIS_ROLL;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_cnt      = r_cnt;
        o_cmd.op   = OP_NOP;
        o_cmd.axis = r_axis;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_axis   = AXIS_ROLL;
                    n_state  = S_STK;
                end
            end
            S_STK: begin
                o_cmd.op = OP_STK;
                n_state  = S_ERR;
            end
            S_ERR: begin
                o_cmd.op = OP_ERR;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = S_PTERM;
            end
            S_PTERM: begin
                o_cmd.op = OP_PTERM;
                n_state  = S_ILO;
            end
            S_ILO: begin
                o_cmd.op = OP_ILO;
                n_state  = S_IHI;
            end
            S_IHI: begin
                o_cmd.op = OP_IHI;
                n_state  = S_ICLIP;
            end
            S_ICLIP: begin
                o_cmd.op = OP_ICLIP;
                n_state  = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.op = OP_DMUL;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.op = OP_FIN;
                if (r_axis == AXIS_YAW) begin
                    n_state = S_MIX;
                end else begin
                    n_axis  = r_axis + 1'b1;
                    n_state = S_STK;
                end
            end
            S_MIX: begin
                // hold until the result register can take the transaction
                if (i_sts.out_free) begin
                    o_cmd.op = OP_MIX;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/qapm_dp.sv]
// Datapath: config registers, PID state, shared multiplier steps, divider, mixer.
module qapm_dp import qapm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  t_in_item              i_in_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data
);

    logic [31:0] r_rp_p, r_rp_i, r_rp_d, r_yaw_p, r_yaw_i, r_yaw_d;
    logic [35:0] r_stick_ctr;
    logic [47:0] r_angle_ctr;

    t_in_item r_in;
    logic [15:0] r_dt;

    logic signed [47:0] r_integ [AXIS_COUNT];
    logic signed [17:0] r_prev  [AXIS_COUNT];
    logic signed [15:0] r_corr  [AXIS_COUNT];

    logic [17:0]        r_x;
    logic [11:0]        r_q0;
    logic               r_sneg;
    logic signed [17:0] r_e;
    logic signed [47:0] r_acc;
    logic signed [63:0] r_sum;
    logic [55:0]        r_plo, r_phi;
    logic               r_aneg;
    logic [DIV_W-1:0]   r_dq;
    logic [15:0]        r_rem;
    logic               r_dneg;

    logic              r_out_valid;
    t_out_item         r_out;

    // per-axis selections
    logic signed [15:0] angle, actr;
    logic [11:0]        swidth, sctr;
    logic [31:0]        kp, ki, kd;

    always_comb begin
        kp = r_rp_p;
        ki = r_rp_i;
        kd = r_rp_d;
        case (i_cmd.axis)
            AXIS_ROLL: begin
                angle  = r_in.angle_roll;
                actr   = r_angle_ctr[15:0];
                swidth = r_in.roll_stick_width;
                sctr   = r_stick_ctr[23:12];
            end
            AXIS_PITCH: begin
                angle  = r_in.angle_pitch;
                actr   = r_angle_ctr[31:16];
                swidth = r_in.pitch_stick_width;
                sctr   = r_stick_ctr[35:24];
            end
            default: begin
                angle  = r_in.angle_yaw;
                actr   = r_angle_ctr[47:32];
                swidth = r_in.yaw_stick_width;
                sctr   = r_stick_ctr[11:0];
                kp     = r_yaw_p;
                ki     = r_yaw_i;
                kd     = r_yaw_d;
            end
        endcase
    end

    // stick step
    logic signed [12:0] sd;
    logic [11:0]        smag;
    logic [17:0]        sx;
    logic [36:0]        sprod;
    // error step
    logic [18:0]        srem;
    logic [11:0]        sq;
    logic signed [12:0] sterm;
    logic signed [17:0] e_new;
    // integral step
    logic signed [34:0] edt;
    logic signed [48:0] isum;
    logic signed [47:0] acc_sat;
    // products
    logic signed [50:0] pprod;
    logic [47:0]        amag;
    logic [60:0]        pfull;
    logic [60:0]        pclip;
    logic signed [18:0] de;
    logic [18:0]        dmag;
    logic [50:0]        dprod;
    // divider
    logic [16:0]        drem;
    logic [DIV_W-1:0]   ddq;
    // finish
    logic signed [63:0] fsum;
    logic signed [63:0] fbias;
    logic signed [37:0] fshift;
    logic signed [15:0] fout;
    // mix
    logic signed [19:0] mt, mp, mr, my;
    logic signed [19:0] m1, m2, m3, m4;
    logic               cut;

    function automatic logic [10:0] clamp_motor(input logic signed [19:0] v);
        logic [10:0] res;
        if (v < $signed({9'd0, MOTOR_LOW})) begin
            res = MOTOR_LOW;
        end else if (v > $signed({9'd0, MOTOR_HIGH})) begin
            res = MOTOR_HIGH;
        end else begin
            res = v[10:0];
        end
        return res;
    endfunction

    always_comb begin
        sd    = $signed({1'b0, swidth}) - $signed({1'b0, sctr});
        smag  = sd[12] ? 12'(-sd) : sd[11:0];
        sx    = {smag, 6'd0} + {12'd0, STK_ROUND};
        sprod = {19'd0, sx} * {18'd0, STK_RECIP};

        srem  = {1'b0, r_x} - 19'({7'd0, r_q0} * {12'd0, STK_DIV});
        sq    = r_q0 + {11'd0, (srem >= {12'd0, STK_DIV})};
        sterm = r_sneg ? -$signed({1'b0, sq}) : $signed({1'b0, sq});
        e_new = 18'(angle) - 18'(actr) + 18'(sterm);

        edt   = r_e * $signed({1'b0, r_dt});
        isum  = 49'(r_integ[i_cmd.axis]) + 49'(edt);
        if (isum[48] != isum[47]) begin
            acc_sat = isum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            acc_sat = isum[47:0];
        end

        pprod = $signed({1'b0, kp}) * r_e;
        amag  = r_acc[47] ? 48'(-r_acc) : r_acc;

        pfull = {1'b0, r_phi[35:0], 24'd0} + {5'd0, r_plo};
        if ((|r_phi[55:36]) || (pfull > (61'd1 << 60))) begin
            pclip = 61'd1 << 60;
        end else begin
            pclip = pfull;
        end

        de    = 19'(r_e) - 19'(r_prev[i_cmd.axis]);
        dmag  = de[18] ? 19'(-de) : de;
        dprod = {19'd0, kd} * {32'd0, dmag};

        // four restoring division steps per cycle
        drem = {1'b0, r_rem};
        ddq  = r_dq;
        for (int k = 0; k < DIV_BITS; k++) begin
            drem = {drem[15:0], ddq[DIV_W-1]};
            ddq  = {ddq[DIV_W-2:0], 1'b0};
            if (drem >= {1'b0, r_dt}) begin
                drem   = drem - {1'b0, r_dt};
                ddq[0] = 1'b1;
            end
        end

        fsum   = r_sum + (r_dneg ? -$signed({12'd0, r_dq}) : $signed({12'd0, r_dq}));
        fbias  = fsum[63] ? fsum + 64'sd67108863 : fsum;
        fshift = 38'(fbias >>> OUT_SHIFT);
        if (fshift > 38'sd32767) begin
            fout = 16'sd32767;
        end else if (fshift < -38'sd32768) begin
            fout = -16'sd32768;
        end else begin
            fout = fshift[15:0];
        end

        mt  = $signed({8'd0, r_in.throttle_width}) - $signed({9'd0, MIX_OFFSET});
        mr  = 20'(r_corr[AXIS_ROLL]);
        mp  = 20'(r_corr[AXIS_PITCH]);
        my  = 20'(r_corr[AXIS_YAW]);
        m1  = mt - mp - mr - my;
        m2  = mt + mp + mr - my;
        m3  = mt - mp + mr + my;
        m4  = mt + mp - mr + my;
        cut = (r_in.throttle_width <= CUTOFF_WIDTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp_p      <= RST_RP_P;
            r_rp_i      <= RST_RP_I;
            r_rp_d      <= RST_RP_D;
            r_yaw_p     <= RST_YAW_P;
            r_yaw_i     <= RST_YAW_I;
            r_yaw_d     <= RST_YAW_D;
            r_stick_ctr <= RST_STICK_CTR;
            r_angle_ctr <= RST_ANGLE_CTR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RP_P:      r_rp_p      <= i_cfg_wdata[31:0];
                REG_RP_I:      r_rp_i      <= i_cfg_wdata[31:0];
                REG_RP_D:      r_rp_d      <= i_cfg_wdata[31:0];
                REG_YAW_P:     r_yaw_p     <= i_cfg_wdata[31:0];
                REG_YAW_I:     r_yaw_i     <= i_cfg_wdata[31:0];
                REG_YAW_D:     r_yaw_d     <= i_cfg_wdata[31:0];
                REG_STICK_CTR: r_stick_ctr <= i_cfg_wdata[35:0];
                REG_ANGLE_CTR: r_angle_ctr <= i_cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                r_integ[a] <= '0;
                r_prev[a]  <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_FIN: begin
                    r_integ[i_cmd.axis] <= r_acc;
                    r_prev[i_cmd.axis]  <= r_e;
                end
                OP_MIX: begin
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_in <= i_in_data;
                r_dt <= (i_in_data.elapsed_ms == 16'd0) ? 16'd1 : i_in_data.elapsed_ms;
            end
            OP_STK: begin
                r_x    <= sx;
                r_q0   <= sprod[36:STK_SHIFT];
                r_sneg <= sd[12];
            end
            OP_ERR:   r_e   <= e_new;
            OP_ACC:   r_acc <= acc_sat;
            OP_PTERM: r_sum <= 64'(pprod);
            OP_ILO: begin
                r_plo  <= {24'd0, ki} * {32'd0, amag[23:0]};
                r_aneg <= r_acc[47];
            end
            OP_IHI:   r_phi <= {24'd0, ki} * {32'd0, amag[47:24]};
            OP_ICLIP: begin
                r_sum <= r_sum + (r_aneg ? -$signed({3'd0, pclip}) : $signed({3'd0, pclip}));
            end
            OP_DMUL: begin
                r_dq   <= {1'b0, dprod};
                r_rem  <= '0;
                r_dneg <= de[18];
            end
            OP_DIV: begin
                r_dq  <= ddq;
                r_rem <= drem[15:0];
            end
            OP_FIN:   r_corr[i_cmd.axis] <= fout;
            OP_MIX: begin
                r_out.motor_one        <= cut ? MOTOR_CUT : clamp_motor(m1);
                r_out.motor_two        <= cut ? MOTOR_CUT : clamp_motor(m2);
                r_out.motor_three      <= cut ? MOTOR_CUT : clamp_motor(m3);
                r_out.motor_four       <= cut ? MOTOR_CUT : clamp_motor(m4);
                r_out.motors_cut       <= cut;
                r_out.pitch_correction <= r_corr[AXIS_PITCH];
                r_out.roll_correction  <= r_corr[AXIS_ROLL];
                r_out.yaw_correction   <= r_corr[AXIS_YAW];
            end
            default: ;
        endcase
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

[hdl/quad_attitude_pid_mixer_top.sv]
// Top level of the quad-X attitude PID controller and motor mixer.
//
//  channel  | dir | handshake          | payload
//  i_in     | in  | valid/ready        | t_in_item: angles, stick widths, elapsed ms
//  o_out    | out | valid/ready        | t_out_item: four motors, cut flag, corrections
//  cfg      | in  | i_cfg_we, no stall | i_cfg_idx, i_cfg_wdata
//
// Each transaction steps the three axes in turn through the shared multiply steps
// and the 4-bit-per-cycle derivative divider, then one mix step forms the result.
// Ready is high only while the sequencer is idle; a held result stalls the mix step.
// Synchronous active-low reset clears sequencer and PID state, loads config defaults.
module quad_attitude_pid_mixer_top import qapm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qapm_in_if.sink               i_in,
    qapm_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    qapm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    qapm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in.data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

endmodule
